// File: rtl/qalu_pkg.sv
// shared types and constants of the quaternion alu
package qalu_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_ADDS  = 3'd2,
    OP_SCALE = 3'd3,
    OP_CONJ  = 3'd4,
    OP_NORM  = 3'd5
  } op_t;

  // one-hot operation class; all zero for an unknown code
  typedef struct packed {
    logic add;
    logic mul;
    logic adds;
    logic scale;
    logic conj;
    logic norm;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

endpackage

// File: rtl/qalu_front.sv
// front end: takes request words and classifies the operation
module qalu_front #(
  parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH_DEF,
  parameter int WORD_W     = qalu_pkg::CLS_W + 9 * COMP_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   req_type,
  input  logic signed [COMP_WIDTH-1:0] a0,
  input  logic signed [COMP_WIDTH-1:0] a1,
  input  logic signed [COMP_WIDTH-1:0] a2,
  input  logic signed [COMP_WIDTH-1:0] a3,
  input  logic signed [COMP_WIDTH-1:0] b0,
  input  logic signed [COMP_WIDTH-1:0] b1,
  input  logic signed [COMP_WIDTH-1:0] b2,
  input  logic signed [COMP_WIDTH-1:0] b3,
  input  logic signed [COMP_WIDTH-1:0] scalar,
  output logic                         push_valid,
  input  logic                         push_full,
  output logic [WORD_W-1:0]            push_word
);

  logic              hold;
  logic              hold_next;
  logic              accept;
  qalu_pkg::cls_t    cls;

  always_comb begin
    cls = '0;
    case (qalu_pkg::op_t'(req_type))
      qalu_pkg::OP_ADD:   cls.add   = 1'b1;
      qalu_pkg::OP_MUL:   cls.mul   = 1'b1;
      qalu_pkg::OP_ADDS:  cls.adds  = 1'b1;
      qalu_pkg::OP_SCALE: cls.scale = 1'b1;
      qalu_pkg::OP_CONJ:  cls.conj  = 1'b1;
      qalu_pkg::OP_NORM:  cls.norm  = 1'b1;
      default:            cls       = '0;
    endcase
  end

  assign in_stall   = hold & push_full;
  assign accept     = in_valid & ~in_stall;
  assign push_valid = hold;

  always_comb begin
    hold_next = hold;
    if (accept) begin
      hold_next = 1'b1;
    end else if (hold & ~push_full) begin
      hold_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else begin
      hold <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_word <= {cls, a0, a1, a2, a3, b0, b1, b2, b3, scalar};
    end
  end

endmodule

// File: rtl/qalu_queue.sv
// short queue between front and back end
module qalu_queue #(
  parameter int WORD_W = 8,
  parameter int DEPTH  = qalu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WORD_W-1:0] push_word,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output logic [WORD_W-1:0] pop_word
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;
  assign pop_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push & ~do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop & ~do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

// File: rtl/qalu_back.sv
// back end: execution pipeline with products, sums and a one-bit-per-stage square root
module qalu_back #(
  parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF,
  parameter int WORD_W     = qalu_pkg::CLS_W + 9 * COMP_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take_valid,
  output logic                         take,
  input  logic [WORD_W-1:0]            take_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] r0,
  output logic signed [COMP_WIDTH-1:0] r1,
  output logic signed [COMP_WIDTH-1:0] r2,
  output logic signed [COMP_WIDTH-1:0] r3,
  output logic                         overflow
);

  localparam int W  = COMP_WIDTH;
  localparam int N  = W + 1;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;

  localparam logic signed [W:0]    MAX1 = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0]    MIN1 = {2'b11, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXS = {{(W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINS = {{(W+3){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]         CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         CMIN = {1'b1, {(W-1){1'b0}}};

  // saturate a narrow sum, ov in the top bit
  function automatic logic [W:0] sat1(input logic signed [W:0] v);
    logic [W:0] res;
    if (v > MAX1) begin
      res = {1'b1, CMAX};
    end else if (v < MIN1) begin
      res = {1'b1, CMIN};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  // floor shift and saturate a wide sum of products
  function automatic logic [W:0] satw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] sh;
    logic [W:0]           res;
    sh = v >>> FRAC_BITS;
    if (sh > MAXS) begin
      res = {1'b1, CMAX};
    end else if (sh < MINS) begin
      res = {1'b1, CMIN};
    end else begin
      res = {1'b0, sh[W-1:0]};
    end
    return res;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
    return $signed({{2{p[PW-1]}}, p});
  endfunction

  logic adv;
  assign adv  = ~(out_valid & out_stall);
  assign take = take_valid & adv;

  // unpack the queue word
  qalu_pkg::cls_t      w_cls;
  logic signed [W-1:0] w_a [4];
  logic signed [W-1:0] w_b [4];
  logic signed [W-1:0] w_s;

  always_comb begin
    w_cls = qalu_pkg::cls_t'(take_word[WORD_W-1 -: qalu_pkg::CLS_W]);
    for (int i = 0; i < 4; i++) begin
      w_a[i] = take_word[(9-i)*W-1 -: W];
      w_b[i] = take_word[(5-i)*W-1 -: W];
    end
    w_s = take_word[W-1:0];
  end

  // stage a: operand select and the add-type results
  logic                va;
  qalu_pkg::cls_t      cls_a;
  logic signed [W-1:0] a_a [4];
  logic signed [W-1:0] m_a [4];
  logic [W-1:0]        sr_a [4];
  logic                sov_a;

  logic signed [W-1:0] m_n [4];
  logic [W-1:0]        sr_n [4];
  logic                sov_n;
  logic [W:0]          st;

  always_comb begin
    sov_n = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sr_n[i] = '0;
      m_n[i]  = w_b[i];
      if (w_cls.scale) begin
        m_n[i] = w_s;
      end else if (w_cls.norm) begin
        m_n[i] = w_a[i];
      end
    end
    st = '0;
    if (w_cls.add) begin
      for (int i = 0; i < 4; i++) begin
        st      = sat1($signed({w_a[i][W-1], w_a[i]}) + $signed({w_b[i][W-1], w_b[i]}));
        sr_n[i] = st[W-1:0];
        sov_n   = sov_n | st[W];
      end
    end else if (w_cls.adds) begin
      st      = sat1($signed({w_a[0][W-1], w_a[0]}) + $signed({w_s[W-1], w_s}));
      sr_n[0] = st[W-1:0];
      sov_n   = st[W];
      for (int i = 1; i < 4; i++) begin
        sr_n[i] = w_a[i];
      end
    end else if (w_cls.conj) begin
      sr_n[0] = w_a[0];
      for (int i = 1; i < 4; i++) begin
        st      = sat1(-$signed({w_a[i][W-1], w_a[i]}));
        sr_n[i] = st[W-1:0];
        sov_n   = sov_n | st[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= take_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_a <= w_cls;
      sov_a <= sov_n;
      for (int i = 0; i < 4; i++) begin
        a_a[i]  <= w_a[i];
        m_a[i]  <= m_n[i];
        sr_a[i] <= sr_n[i];
      end
    end
  end

  // stage b: product matrix
  logic                 vb;
  qalu_pkg::cls_t       cls_b;
  logic signed [PW-1:0] p_b [4][4];
  logic [W-1:0]         sr_b [4];
  logic                 sov_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_b <= cls_a;
      sov_b <= sov_a;
      for (int i = 0; i < 4; i++) begin
        sr_b[i] <= sr_a[i];
        for (int j = 0; j < 4; j++) begin
          p_b[i][j] <= a_a[i] * m_a[j];
        end
      end
    end
  end

  // stage c: sums, shift and saturate; radicand for the norm
  logic signed [SW-1:0] e [4];
  logic [W:0]           t [4];
  logic [W-1:0]         r_n [4];
  logic                 ov_n;
  logic [SW-1:0]        rad_n;

  always_comb begin
    e[0] = ext(p_b[0][0]) - ext(p_b[1][1]) - ext(p_b[2][2]) - ext(p_b[3][3]);
    e[1] = ext(p_b[0][1]) + ext(p_b[1][0]) + ext(p_b[2][3]) - ext(p_b[3][2]);
    e[2] = ext(p_b[0][2]) - ext(p_b[1][3]) + ext(p_b[2][0]) + ext(p_b[3][1]);
    e[3] = ext(p_b[0][3]) + ext(p_b[1][2]) - ext(p_b[2][1]) + ext(p_b[3][0]);
    ov_n = sov_b;
    for (int i = 0; i < 4; i++) begin
      r_n[i] = sr_b[i];
      t[i]   = '0;
    end
    if (cls_b.mul) begin
      ov_n = 1'b0;
      for (int i = 0; i < 4; i++) begin
        t[i]   = satw(e[i]);
        r_n[i] = t[i][W-1:0];
        ov_n   = ov_n | t[i][W];
      end
    end else if (cls_b.scale) begin
      ov_n = 1'b0;
      for (int i = 0; i < 4; i++) begin
        t[i]   = satw(ext(p_b[i][i]));
        r_n[i] = t[i][W-1:0];
        ov_n   = ov_n | t[i][W];
      end
    end
    // squares are never negative
    rad_n = {2'b00, p_b[0][0]} + {2'b00, p_b[1][1]}
          + {2'b00, p_b[2][2]} + {2'b00, p_b[3][3]};
  end

  // square root stages, two radicand bits per stage
  logic         sv   [N+1];
  logic         snrm [N+1];
  logic [W-1:0] sr   [N+1][4];
  logic         sov  [N+1];
  logic [SW-1:0] srad [N+1];
  logic [N+1:0] srem [N+1];
  logic [N-1:0] sq   [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snrm[0] <= cls_b.norm;
      sov[0]  <= ov_n;
      srad[0] <= rad_n;
      srem[0] <= '0;
      sq[0]   <= '0;
      for (int i = 0; i < 4; i++) begin
        sr[0][i] <= r_n[i];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_root
    logic [N+2:0] rem_t;
    logic [N+2:0] trial;
    logic         fit;

    assign rem_t = {srem[k][N:0], srad[k][SW-1 -: 2]};
    assign trial = {1'b0, sq[k], 2'b01};
    assign fit   = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        snrm[k+1] <= snrm[k];
        sov[k+1]  <= sov[k];
        srad[k+1] <= {srad[k][SW-3:0], 2'b00};
        srem[k+1] <= fit ? (N+2)'(rem_t - trial) : rem_t[N+1:0];
        sq[k+1]   <= {sq[k][N-2:0], fit};
        for (int i = 0; i < 4; i++) begin
          sr[k+1][i] <= sr[k][i];
        end
      end
    end
  end

  // output register
  logic root_big;
  assign root_big = (sq[N][N-1 -: 2] != 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (snrm[N]) begin
        r0       <= root_big ? CMAX : sq[N][W-1:0];
        r1       <= '0;
        r2       <= '0;
        r3       <= '0;
        overflow <= root_big;
      end else begin
        r0       <= sr[N][0];
        r1       <= sr[N][1];
        r2       <= sr[N][2];
        r3       <= sr[N][3];
        overflow <= sov[N];
      end
    end
  end

endmodule

// File: rtl/quaternion_alu_top.sv
// top level of the quaternion alu: front end, queue and execution back end
//
//   channel   direction  handshake            word
//   request   in         in_valid / in_stall  req_type, a0..a3, b0..b3, scalar
//   result    out        out_valid / out_stall r0..r3, overflow
//
// one word per cycle sustained while the result is not stalled; every operation flows through the same pipeline
// a word passes the front register, the queue, the operand, product and sum stages,
// COMP_WIDTH + 1 square root stages and the output register
// the square root pipeline, one result bit per stage, sets the depth
// rst is synchronous and clears only the valid bits, queue pointers and queue count
// a stalled result freezes the back end; the queue keeps taking words until it fills
module quaternion_alu_top #(
  parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   req_type,
  input  logic signed [COMP_WIDTH-1:0] a0,
  input  logic signed [COMP_WIDTH-1:0] a1,
  input  logic signed [COMP_WIDTH-1:0] a2,
  input  logic signed [COMP_WIDTH-1:0] a3,
  input  logic signed [COMP_WIDTH-1:0] b0,
  input  logic signed [COMP_WIDTH-1:0] b1,
  input  logic signed [COMP_WIDTH-1:0] b2,
  input  logic signed [COMP_WIDTH-1:0] b3,
  input  logic signed [COMP_WIDTH-1:0] scalar,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] r0,
  output logic signed [COMP_WIDTH-1:0] r1,
  output logic signed [COMP_WIDTH-1:0] r2,
  output logic signed [COMP_WIDTH-1:0] r3,
  output logic                         overflow
);

  // queue word: operation class, then a0..a3, b0..b3, scalar
  localparam int WORD_W = qalu_pkg::CLS_W + 9 * COMP_WIDTH;

  logic              push_valid;
  logic              push_full;
  logic [WORD_W-1:0] push_word;
  logic              pop_valid;
  logic              pop;
  logic [WORD_W-1:0] pop_word;

  // front end: input register and operation decode
  qalu_front #(
    .COMP_WIDTH (COMP_WIDTH),
    .WORD_W     (WORD_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .a0         (a0),
    .a1         (a1),
    .a2         (a2),
    .a3         (a3),
    .b0         (b0),
    .b1         (b1),
    .b2         (b2),
    .b3         (b3),
    .scalar     (scalar),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_word  (push_word)
  );

  // decoupling queue
  qalu_queue #(
    .WORD_W (WORD_W),
    .DEPTH  (qalu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_word (push_word),
    .full      (push_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_word  (pop_word)
  );

  // back end: arithmetic pipeline and result register
  qalu_back #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .WORD_W     (WORD_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .take_valid (pop_valid),
    .take       (pop),
    .take_word  (pop_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .r0         (r0),
    .r1         (r1),
    .r2         (r2),
    .r3         (r3),
    .overflow   (overflow)
  );

endmodule

// File: sim/quaternion_alu_checker.sv
// checker: watches both channels, predicts each result word and compares
`timescale 1ns / 1ps
module quaternion_alu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] a0,
  input  logic signed [15:0] a1,
  input  logic signed [15:0] a2,
  input  logic signed [15:0] a3,
  input  logic signed [15:0] b0,
  input  logic signed [15:0] b1,
  input  logic signed [15:0] b2,
  input  logic signed [15:0] b3,
  input  logic signed [15:0] scalar,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] r0,
  input  logic signed [15:0] r1,
  input  logic signed [15:0] r2,
  input  logic signed [15:0] r3,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic        ov;
  } qres_t;

  qres_t result_fifo[$];

  localparam longint QMAX = 32767;
  localparam longint QMIN = -32768;

  function automatic longint clip(longint v, ref bit ov);
    if (v > QMAX) begin
      ov = 1;
      return QMAX;
    end
    if (v < QMIN) begin
      ov = 1;
      return QMIN;
    end
    return v;
  endfunction

  // products fit easily in 64 bits at 16-bit components; >>> floors
  function automatic longint fx(longint s);
    return s >>> 12;
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r = r + 1;
    return r;
  endfunction

  function automatic qres_t quat_predict(logic [2:0] op, longint a[4], longint b[4],
                                         longint s);
    qres_t q;
    longint r[4];
    longint sum;
    bit ov;
    ov = 0;
    r = '{0, 0, 0, 0};
    case (op)
      qalu_pkg::OP_ADD:
        for (int i = 0; i < 4; i++) r[i] = clip(a[i] + b[i], ov);
      qalu_pkg::OP_MUL: begin
        r[0] = clip(fx(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]), ov);
        r[1] = clip(fx(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]), ov);
        r[2] = clip(fx(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]), ov);
        r[3] = clip(fx(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]), ov);
      end
      qalu_pkg::OP_ADDS: begin
        r[0] = clip(a[0] + s, ov);
        r[1] = a[1];
        r[2] = a[2];
        r[3] = a[3];
      end
      qalu_pkg::OP_SCALE:
        for (int i = 0; i < 4; i++) r[i] = clip(fx(a[i] * s), ov);
      qalu_pkg::OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clip(-a[i], ov);
      end
      qalu_pkg::OP_NORM: begin
        sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        r[0] = clip(root_floor(sum), ov);
      end
      default: ;
    endcase
    q.c0 = r[0][15:0];
    q.c1 = r[1][15:0];
    q.c2 = r[2][15:0];
    q.c3 = r[3][15:0];
    q.ov = ov;
    return q;
  endfunction

  assign pending = result_fifo.size();

  always @(posedge clk) begin
    qres_t want;
    longint a[4];
    longint b[4];
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        a = '{a0, a1, a2, a3};
        b = '{b0, b1, b2, b3};
        result_fifo.push_back(quat_predict(req_type, a, b, longint'(scalar)));
      end
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result word r=%h %h %h %h ov=%b",
                   $time, r0, r1, r2, r3, overflow);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if ({r0, r1, r2, r3, overflow} !== want) begin
            $display("%0t: mismatch expected r=%h %h %h %h ov=%b actual r=%h %h %h %h ov=%b",
                     $time, want.c0, want.c1, want.c2, want.c3, want.ov,
                     r0, r1, r2, r3, overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/quaternion_alu_top_test.sv
// testbench top: drives request words and result stalls, gives the verdict
`timescale 1ns / 1ps
module quaternion_alu_top_test;

  localparam int N_RANDOM = 450;
  localparam int LIMIT = 200000;
  localparam int DRAIN = 60;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] req_type = '0;
  logic signed [15:0] a0 = 0, a1 = 0, a2 = 0, a3 = 0;
  logic signed [15:0] b0 = 0, b1 = 0, b2 = 0, b3 = 0, scalar = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] r0, r1, r2, r3;
  logic overflow;
  int fail_count, pending, checked;
  int cycle = 0;
  bit hold_done = 0;

  always #1 clk = ~clk;

  quaternion_alu_top dut (.*);

  quaternion_alu_checker chk (.*);

  // watchdog on total cycles
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random component: extremes often, otherwise full range or small values
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // gap length: mostly zero or short, a few long
  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one request word and hold it until accepted
  task automatic send_word(logic [2:0] op, logic [15:0] x[4], logic [15:0] y[4],
                           logic [15:0] s);
    req_type <= op;
    {a0, a1, a2, a3} <= {x[0], x[1], x[2], x[3]};
    {b0, b1, b2, b3} <= {y[0], y[1], y[2], y[3]};
    scalar <= s;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: one long hold-off early on to fill the queue, then random stalls
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    repeat (30) @(posedge clk);
    out_stall <= 1;
    repeat (120) @(posedge clk);
    out_stall <= 0;
    hold_done = 1;
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        n = rand_gap();
        out_stall <= (n > 0);
        repeat (n > 0 ? n : 1) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] x[4], y[4];
    logic [15:0] s;
    logic [2:0] op;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every operation at the extremes, plus unknown codes
    for (int k = 0; k < 8; k++) begin
      x = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
      y = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
      send_word(3'(k), x, y, 16'h8000);
    end
    for (int k = 0; k < 6; k++) begin
      x = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
      y = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
      send_word(3'(k), x, y, 16'h7fff);
    end
    // conjugate of most negative, norm of zero and of x, small scale, add scalar pass-through, x times x
    x = '{16'h1000, 16'h8000, 16'h0001, 16'hffff};
    y = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    send_word(qalu_pkg::OP_CONJ, x, y, 16'h0000);
    send_word(qalu_pkg::OP_NORM, y, y, 16'h0000);
    send_word(qalu_pkg::OP_NORM, x, y, 16'h0000);
    send_word(qalu_pkg::OP_SCALE, x, y, 16'hf000);
    send_word(qalu_pkg::OP_ADDS, x, y, 16'h7fff);
    send_word(qalu_pkg::OP_MUL, x, x, 16'h0000);

    // random part: keep offering while the receiver holds off
    for (int k = 0; k < N_RANDOM; k++) begin
      if (hold_done) idle_gap(rand_gap());
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      for (int i = 0; i < 4; i++) begin
        x[i] = rand_comp();
        y[i] = rand_comp();
      end
      s = rand_comp();
      send_word(op, x, y, s);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d request words over all six operations and unknown codes,", checked);
    $display("with saturating extremes, random gaps and a long result hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
